// ===== src/strip_fan_to_triangle_list_defines.svh =====
// Assertion macros shared by the strip and fan assembler checker.
`ifndef STRIP_FAN_TO_TRIANGLE_LIST_DEFINES_SVH
`define STRIP_FAN_TO_TRIANGLE_LIST_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define SFTTL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define SFTTL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sfttl_pkg.sv =====
// Package with the types and constants of the strip and fan assembler.
`default_nettype none
package sfttl_pkg;

    localparam int TEX_W          = 32;
    localparam int VERT_W         = 11;
    localparam int COUNT_W        = 12;
    localparam int LEFT_W         = 12;
    localparam int SEEN_W         = 2;
    localparam int MAX_PRIM_VERTS = 2048;

    // Item kind codes.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // Open primitive.
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [TEX_W-1:0]  s;
        logic [TEX_W-1:0]  t;
        logic [VERT_W-1:0] index;
    } t_corner;

    typedef struct packed {
        t_corner a;
        t_corner b;
        t_corner c;
        logic    list_end;
    } t_tri;

    typedef struct packed {
        logic                      kind;
        logic signed [COUNT_W-1:0] prim_count;
        t_corner                   vert;
    } t_in_item;

endpackage
`default_nettype wire

// ===== src/sfttl_if.sv =====
// Request channel interfaces for command items and assembled triangles.
`default_nettype none
interface sfttl_in_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        kind;
    logic signed [sfttl_pkg::COUNT_W-1:0]        prim_count;
    logic        [sfttl_pkg::TEX_W-1:0]          tex_s;
    logic        [sfttl_pkg::TEX_W-1:0]          tex_t;
    logic        [sfttl_pkg::VERT_W-1:0]         vert_index;

    modport source (output valid, kind, prim_count, tex_s, tex_t, vert_index, input ready);
    modport sink   (input valid, kind, prim_count, tex_s, tex_t, vert_index, output ready);
endinterface

interface sfttl_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfttl_pkg::TEX_W-1:0]    a_s;
    logic [sfttl_pkg::TEX_W-1:0]    a_t;
    logic [sfttl_pkg::VERT_W-1:0]   a_index;
    logic [sfttl_pkg::TEX_W-1:0]    b_s;
    logic [sfttl_pkg::TEX_W-1:0]    b_t;
    logic [sfttl_pkg::VERT_W-1:0]   b_index;
    logic [sfttl_pkg::TEX_W-1:0]    c_s;
    logic [sfttl_pkg::TEX_W-1:0]    c_t;
    logic [sfttl_pkg::VERT_W-1:0]   c_index;
    logic                           list_end;

    modport source (output valid, a_s, a_t, a_index, b_s, b_t, b_index,
                    c_s, c_t, c_index, list_end, input ready);
    modport sink   (input valid, a_s, a_t, a_index, b_s, b_t, b_index,
                    c_s, c_t, c_index, list_end, output ready);
endinterface
`default_nettype wire

// ===== src/strip_fan_to_triangle_list.sv =====
// Triangles and end markers are registered in the result register, or the skid stage on a stall.
// Throughput: one command item per cycle; the result register plus a one-entry skid stage
// keep input ready high while the output is taken every cycle.
// Input ready drops only when both result register and skid stage hold unclaimed results.
// Reset is synchronous, active low: no primitive is open and both result stages are empty.
`default_nettype none
module strip_fan_to_triangle_list #(
    parameter int MAX_PRIM_VERTS = sfttl_pkg::MAX_PRIM_VERTS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfttl_in_if.sink     i_in,
    sfttl_out_if.source  o_out
);
    import sfttl_pkg::*;

    t_in_item w_item;
    t_tri     w_tri;
    t_tri     w_out_tri;
    logic     w_emit;
    logic     w_buf_ready;
    logic     w_take;

    // Input request handshake.
    assign i_in.ready = w_buf_ready;
    assign w_take     = i_in.valid && w_buf_ready;

    assign w_item.kind       = i_in.kind;
    assign w_item.prim_count = i_in.prim_count;
    assign w_item.vert.s     = i_in.tex_s;
    assign w_item.vert.t     = i_in.tex_t;
    assign w_item.vert.index = i_in.vert_index;

    sfttl_core #(
        .MAX_PRIM_VERTS (MAX_PRIM_VERTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_item),
        .o_emit  (w_emit),
        .o_tri   (w_tri)
    );

    sfttl_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_take && w_emit),
        .i_tri       (w_tri),
        .o_ready     (w_buf_ready),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_tri       (w_out_tri)
    );

    // Output request payload.
    assign o_out.a_s      = w_out_tri.a.s;
    assign o_out.a_t      = w_out_tri.a.t;
    assign o_out.a_index  = w_out_tri.a.index;
    assign o_out.b_s      = w_out_tri.b.s;
    assign o_out.b_t      = w_out_tri.b.t;
    assign o_out.b_index  = w_out_tri.b.index;
    assign o_out.c_s      = w_out_tri.c.s;
    assign o_out.c_t      = w_out_tri.c.t;
    assign o_out.c_index  = w_out_tri.c.index;
    assign o_out.list_end = w_out_tri.list_end;

endmodule
`default_nettype wire

// ===== src/sfttl_core.sv =====
// Primitive state and triangle assembly for one accepted command item.
`default_nettype none
module sfttl_core #(
    parameter int MAX_PRIM_VERTS = sfttl_pkg::MAX_PRIM_VERTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire sfttl_pkg::t_in_item i_item,
    output logic                     o_emit,
    output sfttl_pkg::t_tri          o_tri
);
    import sfttl_pkg::*;

    localparam int CMP_W = COUNT_W + 2;
    localparam logic signed [CMP_W-1:0] LP_MAX = CMP_W'(MAX_PRIM_VERTS);
    localparam logic signed [CMP_W-1:0] LP_MIN = CMP_W'(3);

    t_mode              r_mode, n_mode;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic               r_flip, n_flip;
    t_corner            r_centre, n_centre;
    t_corner            r_older, n_older;
    t_corner            r_newer, n_newer;

    logic signed [CMP_W-1:0] w_count;
    logic [COUNT_W:0]        w_neg;
    logic                    w_is_strip;
    logic                    w_is_fan;
    logic                    w_header;
    logic                    w_vert_open;

    // Header decode on a sign-extended count.
    assign w_count    = CMP_W'(i_item.prim_count);
    assign w_neg      = (COUNT_W + 1)'(-w_count);
    assign w_is_strip = (w_count >= LP_MIN) && (w_count < LP_MAX);
    assign w_is_fan   = (w_count <= -LP_MIN) && (w_count > -LP_MAX);
    assign w_header   = i_take && (i_item.kind == KIND_HEADER);
    assign w_vert_open = i_take && (i_item.kind == KIND_VERTEX)
                       && (r_mode != MODE_NONE) && (r_left != '0);

    // Next state of the open primitive and the vertex history.
    always_comb begin
        n_mode   = r_mode;
        n_left   = r_left;
        n_seen   = r_seen;
        n_flip   = r_flip;
        n_centre = r_centre;
        n_older  = r_older;
        n_newer  = r_newer;
        if (w_header) begin
            n_seen = '0;
            n_flip = 1'b0;
            if (w_is_strip) begin
                n_mode = MODE_STRIP;
                n_left = w_count[LEFT_W-1:0];
            end else if (w_is_fan) begin
                n_mode = MODE_FAN;
                n_left = w_neg[LEFT_W-1:0];
            end else begin
                n_mode = MODE_NONE;
                n_left = '0;
            end
        end else if (w_vert_open) begin
            case (r_seen)
                2'd0: begin
                    n_centre = i_item.vert;
                    n_older  = i_item.vert;
                    n_seen   = 2'd1;
                end
                2'd1: begin
                    n_newer = i_item.vert;
                    n_seen  = 2'd2;
                end
                default: begin
                    if (r_seen == 2'd3 && r_mode == MODE_STRIP) begin
                        n_flip = ~r_flip;
                    end
                    n_older = r_newer;
                    n_newer = i_item.vert;
                    n_seen  = 2'd3;
                end
            endcase
            n_left = r_left - 1'b1;
            if (n_left == '0) begin
                n_mode = MODE_NONE;
            end
        end
    end

    // Triangle or end marker for the item being accepted.
    always_comb begin
        o_emit = 1'b0;
        o_tri  = '0;
        if (w_header) begin
            if (!w_is_strip && !w_is_fan) begin
                o_emit        = 1'b1;
                o_tri.list_end = 1'b1;
            end
        end else if (w_vert_open && r_seen[1]) begin
            o_emit = 1'b1;
            o_tri.c = i_item.vert;
            if (r_seen == 2'd2) begin
                o_tri.a = r_older;
                o_tri.b = r_newer;
            end else if (r_mode == MODE_FAN) begin
                o_tri.a = i_item.vert;
                o_tri.b = r_centre;
                o_tri.c = r_newer;
            end else if (!r_flip) begin
                o_tri.a = r_newer;
                o_tri.b = r_older;
            end else begin
                o_tri.a = r_older;
                o_tri.b = r_newer;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_left <= '0;
            r_seen <= '0;
            r_flip <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_seen <= n_seen;
            r_flip <= n_flip;
        end
    end

    // Vertex history.
    always_ff @(posedge i_clk) begin
        r_centre <= n_centre;
        r_older  <= n_older;
        r_newer  <= n_newer;
    end

endmodule
`default_nettype wire

// ===== src/sfttl_out_buf.sv =====
// Result register with a skid stage for the triangle channel.
`default_nettype none
module sfttl_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sfttl_pkg::t_tri i_tri,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_pop_ready,
    output sfttl_pkg::t_tri      o_tri
);
    import sfttl_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_tri r_main;
    t_tri r_skid;
    logic w_pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_tri   = r_main;
    assign w_pop   = r_main_valid && i_pop_ready;

    // Valid flags: the skid stage fills only when the result register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !w_pop) begin
                r_skid <= i_tri;
            end else begin
                r_main <= i_tri;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/sfttl_checker.sv =====
// Port-level checks of the strip and fan assembler, bound to the top level.
`default_nettype none
`include "strip_fan_to_triangle_list_defines.svh"
module sfttl_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_in_kind,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_out_list_end,
    input wire logic [sfttl_pkg::VERT_W-1:0]  i_out_a_index
);
    import sfttl_pkg::*;

    // A stalled output request keeps its payload.
    `SFTTL_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_list_end) && $stable(i_out_a_index), "output request changed while stalled")

    // Both result stages are empty after reset.
    `SFTTL_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !i_out_valid && i_in_ready, "result stages not empty after reset")

    // A vertex taken into an empty output never yields an end marker.
    `SFTTL_ASSERT(a_vertex_no_end, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_kind == KIND_VERTEX && !i_out_valid |=> !i_out_list_end || !i_out_valid, "vertex produced an end marker")

    // Input ready falls only after a stalled output request.
    `SFTTL_ASSERT(a_ready_fall, i_clk, i_rst_n, $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready), "input ready fell without output stall")

    // Input ready low means a result is waiting at the output.
    `SFTTL_ASSERT(a_stall_has_out, i_clk, i_rst_n, !i_in_ready |-> i_out_valid, "input stalled with empty output")

endmodule

bind strip_fan_to_triangle_list sfttl_checker u_sfttl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_kind      (i_in.kind),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_list_end (o_out.list_end),
    .i_out_a_index  (o_out.a_index)
);
`default_nettype wire
